[rtl/velocity_polar_cartesian_unit_top_assert.svh]
// ----------------------------------------------------------------------------
// Velocity unit assertion macros
// Shorthand for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_POLAR_CARTESIAN_UNIT_TOP_ASSERT_SVH
`define VELOCITY_POLAR_CARTESIAN_UNIT_TOP_ASSERT_SVH

// Same-cycle implication.
`define VPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/vpc_pkg.sv]
// ----------------------------------------------------------------------------
// Velocity unit package
// Shared types, operation codes and the whole-degree sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vpc_pkg;

  typedef enum logic [1:0] {
    FUNC_POLAR = 2'd0,
    FUNC_SET_X = 2'd1,
    FUNC_SET_Y = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_ROUND,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_FINISH
  } state_t;

  localparam int unsigned SIN_W = 31;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

  typedef logic [90:0][SIN_W-1:0] sin_tab_t;

  // Unsigned 64-bit long division, used only while the table is built.
  function automatic longint unsigned udiv64(longint unsigned num,
                                             longint unsigned dvs);
    logic [64:0] rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, dvs}) begin
        rem    = rem - {1'b0, dvs};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine of each whole degree 0..90 in unsigned Q1.30, odd Taylor series.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    longint unsigned xq;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned den;
    longint sum;
    for (int d = 0; d <= 90; d++) begin
      if (d == 0) begin
        tab[d] = '0;
      end else if (d == 90) begin
        tab[d] = SIN_W'(ONE_Q30);
      end else begin
        xq = udiv64(longint'(d) * PI_Q30 + 64'd90, 64'd180);
        x2 = (xq * xq + (64'd1 << 29)) >> 30;
        term = xq;
        sum = longint'(xq);
        for (int n = 1; n <= 8; n++) begin
          den = longint'((2 * n) * (2 * n + 1)) << 30;
          term = udiv64(term * x2 + (den >> 1), den);
          if ((n & 1) == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum > longint'(ONE_Q30)) begin
          sum = longint'(ONE_Q30);
        end
        if (sum < 0) begin
          sum = 0;
        end
        tab[d] = SIN_W'(sum);
      end
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

`default_nettype wire

[rtl/velocity_polar_cartesian_unit_top.sv]
// Polar set: 32 serial multiply steps, then a rounding state, from input transaction to result.
// Component set: 32 serial square steps, then 32 square-root steps.
// No-op code: the result is loaded without any arithmetic. One item is worked on at a time;
// the next input transaction can be taken in the cycle after a result is loaded, and a result
// waits while the output register is still full.
// Reset (synchronous, rst_n low) clears the vector, length and direction to zero.
// ----------------------------------------------------------------------------
// Velocity polar/Cartesian unit
// Holds a 2-D velocity and converts between polar and Cartesian forms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "velocity_polar_cartesian_unit_top_assert.svh"

module velocity_polar_cartesian_unit_top
  import vpc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // speed[31:0], heading_deg[40:32], component_value[72:41], zero pad
  input  wire logic [79:0]  in_tdata,
  // func[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // x_out[31:0], y_out[63:32], magnitude_out[94:64], angle_out[103:95]
  output logic      [103:0] out_tdata
);

  state_t state_r, state_nxt;

  logic [31:0]  x_r;
  logic [31:0]  y_r;
  logic [30:0]  len_r;
  logic [8:0]   dir_r;
  logic         recomp_r;
  logic         xneg_r;
  logic         yneg_r;
  logic         axis_r;
  logic [8:0]   base_r;
  logic [4:0]   cnt_r;
  logic [63:0]  rad_r;
  logic [34:0]  rem_r;
  logic [31:0]  root_r;
  logic         out_valid_r;
  logic [103:0] out_data_r;

  logic         accept;
  logic         out_load;
  logic         mul_load;
  logic         mul_en;
  logic         root_en;
  logic         cnt_last;
  logic         ang_start;
  logic         ang_busy;
  logic [6:0]   ang_deg;
  logic [31:0]  mx_a, mx_b, my_a, my_b;
  logic [63:0]  px, py;

  // Polar decode of the incoming item.
  logic [30:0]  sp_clamp;
  logic [8:0]   hd, hm, qbase;
  logic [1:0]   quad;
  logic [6:0]   rdeg;
  logic [30:0]  s_val, c_val;
  logic [30:0]  cs_mag, sn_mag;
  logic         cs_neg, sn_neg;

  // Component-set preparation.
  logic [31:0]  ax, ay, au, av;
  logic         axis_c;
  logic [8:0]   base_c;

  logic [63:0]  xr_sum, yr_sum;
  logic [34:0]  rem_sh, trial;
  logic [30:0]  len_fin;
  logic [8:0]   dir_fin;

  assign accept   = in_tvalid && in_tready;
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || out_tready);
  assign cnt_last = (cnt_r == 5'd31);

  assign sp_clamp = in_tdata[31] ? 31'd0 : in_tdata[30:0];
  assign hd       = in_tdata[40:32];
  assign hm       = (hd >= 9'd360) ? (hd - 9'd360) : hd;

  always_comb begin
    if (hm >= 9'd270) begin
      quad  = 2'd3;
      qbase = 9'd270;
    end else if (hm >= 9'd180) begin
      quad  = 2'd2;
      qbase = 9'd180;
    end else if (hm >= 9'd90) begin
      quad  = 2'd1;
      qbase = 9'd90;
    end else begin
      quad  = 2'd0;
      qbase = 9'd0;
    end
  end

  assign rdeg  = 7'(hm - qbase);
  assign s_val = SIN_TAB[rdeg];
  assign c_val = SIN_TAB[7'd90 - rdeg];

  always_comb begin
    case (quad)
      2'd0: begin
        cs_mag = c_val; cs_neg = 1'b0; sn_mag = s_val; sn_neg = 1'b0;
      end
      2'd1: begin
        cs_mag = s_val; cs_neg = 1'b1; sn_mag = c_val; sn_neg = 1'b0;
      end
      2'd2: begin
        cs_mag = c_val; cs_neg = 1'b1; sn_mag = s_val; sn_neg = 1'b1;
      end
      default: begin
        cs_mag = s_val; cs_neg = 1'b0; sn_mag = c_val; sn_neg = 1'b1;
      end
    endcase
  end

  assign ax = x_r[31] ? (~x_r + 32'd1) : x_r;
  assign ay = y_r[31] ? (~y_r + 32'd1) : y_r;

  always_comb begin
    axis_c = 1'b0;
    base_c = 9'd0;
    au     = ax;
    av     = ay;
    if (y_r == 32'd0) begin
      axis_c = 1'b1;
      base_c = x_r[31] ? 9'd180 : 9'd0;
    end else if (x_r == 32'd0) begin
      axis_c = 1'b1;
      base_c = y_r[31] ? 9'd270 : 9'd90;
    end else if (!x_r[31] && !y_r[31]) begin
      base_c = 9'd0;
    end else if (x_r[31] && !y_r[31]) begin
      base_c = 9'd90;
      au     = ay;
      av     = ax;
    end else if (x_r[31]) begin
      base_c = 9'd180;
    end else begin
      base_c = 9'd270;
      au     = ay;
      av     = ax;
    end
  end

  assign mx_a = (state_r == ST_IDLE) ? {1'b0, sp_clamp} : ax;
  assign mx_b = (state_r == ST_IDLE) ? {1'b0, cs_mag} : ax;
  assign my_a = (state_r == ST_IDLE) ? {1'b0, sp_clamp} : ay;
  assign my_b = (state_r == ST_IDLE) ? {1'b0, sn_mag} : ay;

  vpc_smul u_mul_x (
    .clk  (clk),
    .load (mul_load),
    .en   (mul_en),
    .a    (mx_a),
    .b    (mx_b),
    .p    (px)
  );

  vpc_smul u_mul_y (
    .clk  (clk),
    .load (mul_load),
    .en   (mul_en),
    .a    (my_a),
    .b    (my_b),
    .p    (py)
  );

  vpc_angle u_angle (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ang_start),
    .u     (au),
    .v     (av),
    .busy  (ang_busy),
    .deg   (ang_deg)
  );

  assign xr_sum = px + (64'd1 << 29);
  assign yr_sum = py + (64'd1 << 29);

  assign rem_sh = {rem_r[32:0], rad_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};

  assign len_fin = recomp_r ? (root_r[31] ? MAG_MAX : root_r[30:0]) : len_r;
  assign dir_fin = recomp_r ? (base_r + (axis_r ? 9'd0 : {2'b00, ang_deg})) : dir_r;

  always_comb begin
    state_nxt = state_r;
    mul_load  = 1'b0;
    mul_en    = 1'b0;
    root_en   = 1'b0;
    ang_start = 1'b0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (func_t'(in_tuser)) inside
            FUNC_POLAR: begin
              mul_load  = 1'b1;
              state_nxt = ST_MUL;
            end
            FUNC_SET_X, FUNC_SET_Y: state_nxt = ST_PREP;
            default:                state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_PREP: begin
        mul_load  = 1'b1;
        ang_start = !axis_c;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        mul_en = 1'b1;
        if (cnt_last) begin
          state_nxt = recomp_r ? ST_ROOT_LOAD : ST_ROUND;
        end
      end
      ST_ROUND:     state_nxt = ST_FINISH;
      ST_ROOT_LOAD: state_nxt = ST_ROOT;
      ST_ROOT: begin
        root_en = 1'b1;
        if (cnt_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= '0;
      y_r         <= '0;
      len_r       <= '0;
      dir_r       <= '0;
      recomp_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (accept) begin
            case (func_t'(in_tuser))
              FUNC_POLAR: begin
                recomp_r <= 1'b0;
                len_r    <= sp_clamp;
                dir_r    <= hm;
                xneg_r   <= cs_neg;
                yneg_r   <= sn_neg;
              end
              FUNC_SET_X: begin
                recomp_r <= 1'b1;
                x_r      <= in_tdata[72:41];
              end
              FUNC_SET_Y: begin
                recomp_r <= 1'b1;
                y_r      <= in_tdata[72:41];
              end
              default: recomp_r <= 1'b0;
            endcase
          end
        end
        ST_PREP: begin
          axis_r <= axis_c;
          base_r <= base_c;
          cnt_r  <= '0;
        end
        ST_MUL: begin
          cnt_r <= cnt_r + 5'd1;
        end
        ST_ROUND: begin
          x_r <= xneg_r ? (~xr_sum[61:30] + 32'd1) : xr_sum[61:30];
          y_r <= yneg_r ? (~yr_sum[61:30] + 32'd1) : yr_sum[61:30];
        end
        ST_ROOT_LOAD: begin
          rad_r  <= px + py;
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= '0;
        end
        ST_ROOT: begin
          if (root_en) begin
            rad_r <= {rad_r[61:0], 2'b00};
            if (rem_sh >= trial) begin
              rem_r  <= rem_sh - trial;
              root_r <= {root_r[30:0], 1'b1};
            end else begin
              rem_r  <= rem_sh;
              root_r <= {root_r[30:0], 1'b0};
            end
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            len_r      <= len_fin;
            dir_r      <= dir_fin;
            out_data_r <= {dir_fin, len_fin, y_r, x_r};
          end
        end
        default: cnt_r <= '0;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `VPC_ASSERT_NXT(a_accept_busy, accept, !in_tready, "input taken while busy")
  `VPC_ASSERT_IMP(a_angle_ready, state_r == ST_ROOT_LOAD && !axis_r, !ang_busy,
                  "angle search not finished before square root")
  `VPC_ASSERT_IMP(a_angle_range, out_tvalid, out_tdata[103:95] < 9'd360,
                  "angle out of range")
  `VPC_ASSERT_NXT(a_out_load, state_r == ST_FINISH && !out_tvalid, out_tvalid,
                  "result not loaded into output register")

endmodule

`default_nettype wire

[rtl/vpc_smul.sv]
// ----------------------------------------------------------------------------
// Velocity unit serial multiplier
// Unsigned 32 x 32 shift-add multiplier, one multiplier bit per cycle while en is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vpc_smul
  import vpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p
);

  logic [31:0] a_r;
  logic [63:0] p_r;
  logic [32:0] add;

  assign add = {1'b0, p_r[63:32]} + (p_r[0] ? {1'b0, a_r} : 33'd0);

  always_ff @(posedge clk) begin
    if (load) begin
      a_r <= a;
      p_r <= {32'd0, b};
    end else if (en) begin
      p_r <= {add, p_r[31:1]};
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

[rtl/vpc_angle.sv]
// ----------------------------------------------------------------------------
// Velocity unit angle search
// Binary search for the floor angle of a first-quadrant vector in degrees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vpc_angle
  import vpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] u,
  input  wire logic [31:0] v,
  output logic             busy,
  output logic      [6:0]  deg
);

  logic [6:0]  lo_r;
  logic [6:0]  hi_r;
  logic        phase_r;
  logic        busy_r;
  logic [31:0] u_r;
  logic [31:0] v_r;
  logic [62:0] lhs_r;
  logic [62:0] rhs_r;
  logic [6:0]  mid;

  assign mid = 7'(({1'b0, lo_r} + {1'b0, hi_r} + 8'd1) >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
    end else if (start) begin
      busy_r  <= 1'b1;
      phase_r <= 1'b0;
      lo_r    <= 7'd0;
      hi_r    <= 7'd89;
      u_r     <= u;
      v_r     <= v;
    end else if (busy_r) begin
      if (!phase_r) begin
        if (lo_r == hi_r) begin
          busy_r <= 1'b0;
        end else begin
          lhs_r   <= {31'd0, v_r} * {32'd0, SIN_TAB[7'd90 - mid]};
          rhs_r   <= {31'd0, u_r} * {32'd0, SIN_TAB[mid]};
          phase_r <= 1'b1;
        end
      end else begin
        if (lhs_r >= rhs_r) begin
          lo_r <= mid;
        end else begin
          hi_r <= mid - 7'd1;
        end
        phase_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign deg  = lo_r;

endmodule

`default_nettype wire
